/* rtl/nbd_pkg.sv */
// ----------------------------------------------------------------------------
// nbd_pkg
// Shared constants, register indexes and cell control type for the
// normalized blur / decimate-by-two block.
// ----------------------------------------------------------------------------
package nbd_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int PIXEL_BITS_DEF  = 16;
    localparam int COEF_BITS_DEF   = 12;
    localparam int KERNEL_SIZE_DEF = 5;

    localparam int HEIGHT_LIMIT = 1024;
    localparam int WIN          = 5;
    localparam int LINES        = 4;
    localparam int TAP_FIELD    = 12;
    localparam int ROW_W        = 11;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 60;
    localparam int OUT_W        = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PARITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_A     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_B     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_C     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_D     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_E     = 3'd7;

    typedef struct packed {
        logic       shift_en;
        logic       prod_en;
        logic       acc_clr;
        logic       acc_en;
        logic       drain_en;
        logic [2:0] sel;
    } nbd_cell_ctl_t;

endpackage

/* rtl/nbd_ram.sv */
// ----------------------------------------------------------------------------
// nbd_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module nbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/nbd_cell.sv */
// ----------------------------------------------------------------------------
// nbd_cell
// One window row: five pixel taps, a multiplier and an accumulator that
// hands its sum to the next cell while draining.
// ----------------------------------------------------------------------------
module nbd_cell import nbd_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int COEF_BITS  = COEF_BITS_DEF,
    parameter int ACC_W      = PIXEL_BITS_DEF + COEF_BITS_DEF + 5
) (
    input  logic                  clk,
    input  nbd_cell_ctl_t         ctl,
    input  logic [PIXEL_BITS-1:0] shift_pix,
    input  logic [COEF_BITS-1:0]  weight,
    input  logic [ACC_W-1:0]      acc_in,
    output logic [ACC_W-1:0]      acc_out
);

    logic [PIXEL_BITS-1:0]           pix_reg [WIN];
    logic [PIXEL_BITS-1:0]           sel_pix;
    logic [PIXEL_BITS+COEF_BITS-1:0] prod_reg;
    logic [ACC_W-1:0]                acc_reg;

    always_comb
    begin
        sel_pix = '0;
        if (ctl.sel < 3'(WIN))
        begin
            sel_pix = pix_reg[ctl.sel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            for (int k = 0; k < WIN - 1; k++)
            begin
                pix_reg[k] <= pix_reg[k+1];
            end
            pix_reg[WIN-1] <= shift_pix;
        end
        if (ctl.prod_en)
        begin
            // taps outside the plane carry zero weight and may hold unwritten data
            if (weight == '0)
            begin
                prod_reg <= '0;
            end
            else
            begin
                prod_reg <= (PIXEL_BITS+COEF_BITS)'(weight)
                          * (PIXEL_BITS+COEF_BITS)'(sel_pix);
            end
        end
        if (ctl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        else if (ctl.drain_en)
        begin
            acc_reg <= acc_in;
        end
    end

    assign acc_out = acc_reg;

endmodule

/* rtl/nbd_div.sv */
// ----------------------------------------------------------------------------
// nbd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nbd_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17,
    parameter int Q_W   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= NUM_W'(den) << (Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[Q_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* rtl/normalized_blur_decimate_by_two.sv */
// ----------------------------------------------------------------------------
// normalized_blur_decimate_by_two
// 5x5 normalized blur over a raster plane, keeping every second row and
// column; line buffer in four RAM banks, window in a chain of row cells.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_stall, kind, pixel_value | into block
//   out     | out_valid, out_stall, reduced_value,  | out of block
//           | plane_last                            |
//   cfg     | cfg_write, cfg_index, cfg_data        | into block
//
// An item that yields no result passes only the accepting and line-read states.
// An item that yields a result passes the accepting cycle, line read,
// multiply-accumulate in the cells, draining of the cell chain, the serial
// divider, then an output load; the input is stalled until the item is through.
// Reset clears counters, control and configuration; datapath registers and the line store are not cleared.
// A stalled output holds the block before its next result is loaded.
// ----------------------------------------------------------------------------
module normalized_blur_decimate_by_two import nbd_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF,
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [15:0]           pixel_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_W-1:0]      reduced_value,
    output logic                  plane_last,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = ((CW + 1 > ROW_W) ? CW + 1 : ROW_W) + 2;
    localparam int HW     = ROW_W + 1;
    localparam int ACC_W  = PIXEL_BITS + COEF_BITS + 5;
    localparam int DEN_W  = COEF_BITS + 5;
    localparam int KLO    = 2 - KERNEL_SIZE / 2;
    localparam int KHI    = KLO + KERNEL_SIZE - 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [ROW_W-1:0]      width_reg;
    logic [ROW_W-1:0]      height_reg;
    logic [1:0]            parity_reg;
    logic [CFG_DATA_W-1:0] kw_reg [WIN];

    logic [2:0]       state_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;
    logic [2:0]       step_reg;
    logic             emit_reg;
    logic             shift_reg;
    logic             last_reg;
    logic [HW-1:0]    rc_reg;
    logic [WW-1:0]    cc_reg;
    logic [1:0]       koff_reg;
    logic [1:0]       rbase_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [ACC_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      reduced_reg;
    logic                  plane_last_reg;

    logic [WW-1:0] w_eff;
    logic [WW-1:0] w_raw;
    logic [HW-1:0] h_eff;
    logic [HW-1:0] h_raw;
    logic [WW-1:0] ce;
    logic [HW-1:0] re;
    logic          accept;
    logic          is_final;
    logic          is_edge;
    logic          is_norm;
    logic          edge_near;
    logic [HW-1:0] rc_next;
    logic [WW-1:0] cc_next;
    logic [1:0]    koff_next;
    logic [PIXEL_BITS-1:0] pix_next;

    logic [PIXEL_BITS-1:0] ram_rdata [LINES];
    logic [PIXEL_BITS-1:0] vec [WIN];
    logic [COEF_BITS-1:0]  cell_wt [WIN];
    logic [ACC_W-1:0]      cell_acc [WIN];
    logic [DEN_W-1:0]      wt_sum;
    nbd_cell_ctl_t         ctl;
    logic                  col_ok;
    logic [WW-1:0]         cj;

    logic                  div_start;
    logic                  div_done;
    logic [PIXEL_BITS-1:0] div_q;
    logic [39:0]           q_ext;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ROW_W'(1024);
            height_reg <= ROW_W'(1024);
            parity_reg <= '0;
            for (int i = 0; i < WIN; i++)
            begin
                kw_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[ROW_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                REG_START_PARITY: parity_reg <= cfg_data[1:0];
                REG_KERNEL_A:     kw_reg[0]  <= cfg_data;
                REG_KERNEL_B:     kw_reg[1]  <= cfg_data;
                REG_KERNEL_C:     kw_reg[2]  <= cfg_data;
                REG_KERNEL_D:     kw_reg[3]  <= cfg_data;
                REG_KERNEL_E:     kw_reg[4]  <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign w_raw = WW'(width_reg);
    assign h_raw = HW'(height_reg);
    assign w_eff = (w_raw == '0) ? WW'(1) : ((w_raw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_raw);
    assign h_eff = (h_raw == '0) ? HW'(1)
                 : ((h_raw > HW'(HEIGHT_LIMIT)) ? HW'(HEIGHT_LIMIT) : h_raw);

    // position decode of the incoming item
    assign ce       = WW'(col_reg);
    assign re       = HW'(row_reg);
    assign accept   = in_valid && !in_stall;
    assign is_final = re >= h_eff + HW'(2);
    assign edge_near = (w_eff[0] == parity_reg[1]) && (w_eff >= WW'(2));
    assign is_edge  = (ce == '0) && (re >= HW'(3)) && (re - HW'(3) < h_eff)
                    && (!row_reg[0] == parity_reg[0])
                    && (edge_near || (w_eff[0] != parity_reg[1]));
    assign is_norm  = !is_edge && !is_final && (ce >= WW'(2)) && (ce < w_eff)
                    && (re >= HW'(2)) && (re - HW'(2) < h_eff)
                    && (row_reg[0] == parity_reg[0]) && (col_reg[0] == parity_reg[1]);
    assign rc_next  = is_edge ? re - HW'(3) : re - HW'(2);
    assign cc_next  = is_edge ? (edge_near ? w_eff - WW'(2) : w_eff - WW'(1)) : ce - WW'(2);
    assign koff_next = is_edge ? (2'(!edge_near) + 2'(is_final)) : 2'd0;
    assign pix_next = (re < h_eff && !kind) ? PIXEL_BITS'(pixel_value) : '0;

    // line store, one bank per row modulo four
    for (genvar b = 0; b < LINES; b++)
    begin : g_bank
        nbd_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (accept && !is_final && (row_reg[1:0] == 2'(b))),
            .waddr (col_reg),
            .wdata (pix_next),
            .raddr (col_reg),
            .rdata (ram_rdata[b])
        );
    end

    always_comb
    begin
        for (int m = 0; m < LINES; m++)
        begin
            vec[m] = ram_rdata[2'(rbase_reg + 2'(m))];
        end
        vec[WIN-1] = pix_reg;
    end

    // tap weights for the current window column
    assign cj     = cc_reg + WW'(step_reg);
    assign col_ok = (cj >= WW'(2)) && (cj < w_eff + WW'(2))
                  && (int'(step_reg) >= KLO) && (int'(step_reg) <= KHI)
                  && (3'(step_reg) + 3'(koff_reg) < 3'(WIN));

    always_comb
    begin
        wt_sum = '0;
        for (int m = 0; m < WIN; m++)
        begin
            cell_wt[m] = '0;
            if (col_ok && (rc_reg + HW'(m) >= HW'(2)) && (rc_reg + HW'(m) < h_eff + HW'(2))
                && (m >= KLO) && (m <= KHI) && (step_reg < 3'(WIN)))
            begin
                cell_wt[m] = kw_reg[m][TAP_FIELD*step_reg +: COEF_BITS];
            end
            wt_sum = wt_sum + DEN_W'(cell_wt[m]);
        end
    end

    always_comb
    begin
        ctl.shift_en = (state_reg == S_SHIFT) && shift_reg;
        ctl.prod_en  = (state_reg == S_MAC) && (step_reg < 3'(WIN));
        ctl.acc_clr  = (state_reg == S_SHIFT);
        ctl.acc_en   = (state_reg == S_MAC) && (step_reg != '0);
        ctl.drain_en = (state_reg == S_DRAIN);
        ctl.sel      = step_reg + 3'(koff_reg);
    end

    for (genvar m = 0; m < WIN; m++)
    begin : g_cell
        nbd_cell #(
            .PIXEL_BITS (PIXEL_BITS),
            .COEF_BITS  (COEF_BITS),
            .ACC_W      (ACC_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .shift_pix (vec[m]),
            .weight    (cell_wt[m]),
            .acc_in    ((m == 0) ? '0 : cell_acc[(m == 0) ? 0 : m - 1]),
            .acc_out   (cell_acc[m])
        );
    end

    assign div_start = (state_reg == S_DRAIN) && (step_reg == 3'(WIN - 1));

    nbd_div #(
        .NUM_W (ACC_W),
        .DEN_W (DEN_W),
        .Q_W   (PIXEL_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg + cell_acc[WIN-1]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign q_ext = (den_reg == '0) ? '0 : 40'(div_q);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_reg        <= '0;
            col_reg        <= '0;
            step_reg       <= '0;
            emit_reg       <= 1'b0;
            shift_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        emit_reg  <= is_edge || is_norm;
                        shift_reg <= !is_final;
                        state_reg <= S_SHIFT;
                        if (is_final)
                        begin
                            row_reg <= '0;
                            col_reg <= '0;
                        end
                        else if (ce + WW'(1) >= w_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                S_SHIFT:
                begin
                    step_reg  <= '0;
                    state_reg <= emit_reg ? S_MAC : S_IDLE;
                end
                S_MAC:
                begin
                    if (step_reg == 3'(WIN))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (step_reg == 3'(WIN - 1))
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rc_reg    <= rc_next;
            cc_reg    <= cc_next;
            koff_reg  <= koff_next;
            rbase_reg <= row_reg[1:0];
            pix_reg   <= pix_next;
            last_reg  <= (rc_next + HW'(2) >= h_eff) && (cc_next + WW'(2) >= w_eff);
        end
        if (state_reg == S_SHIFT)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        if (ctl.prod_en)
        begin
            den_reg <= den_reg + wt_sum;
        end
        if (state_reg == S_DRAIN && !div_start)
        begin
            num_reg <= num_reg + cell_acc[WIN-1];
        end
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            reduced_reg    <= q_ext[OUT_W-1:0];
            plane_last_reg <= last_reg;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign reduced_value = reduced_reg;
    assign plane_last    = plane_last_reg;

    a_final_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_final) |=> (row_reg == '0 && col_reg == '0))
        else $error("position not cleared after final item");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> (state_reg == S_OUT))
        else $error("result overwritten while output stalled");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (WW'(col_reg) < WW'(MAX_WIDTH)))
        else $error("column count out of range");

endmodule
